// ===== rtl/mlt_pkg.sv =====
`timescale 1ns / 1ps
package mlt_pkg;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 16;

  // blink timing in milliseconds
  localparam logic [9:0]  FAST_TICK_MS  = 10'd25;
  localparam logic [9:0]  BLINK_DARK_MS = 10'd150;
  localparam logic [9:0]  BLINK_LIT_MS  = 10'd350;
  localparam logic [2:0]  BLINK_STEPS   = 3'd6;   // three dark/lit pairs
  localparam logic [15:0] WARN_SECONDS  = 16'd3;
  localparam logic [6:0]  FULL_DUTY     = 7'd100;

  localparam logic [15:0] RST_ON_TIME  = 16'd60;
  localparam logic [6:0]  RST_SENS     = 7'd50;
  localparam logic [11:0] RST_MARGIN   = 12'd300;

  typedef enum logic [1:0] {
    CMD_SECOND = 2'd0,
    CMD_FAST   = 2'd1,
    CMD_MOTION = 2'd2
  } cmd_t;

  typedef enum logic [CfgIndexW-1:0] {
    REG_ON_TIME      = 3'd0,
    REG_SENSITIVITY  = 3'd1,
    REG_AUTO_MODE    = 3'd2,
    REG_LIGHT_MARGIN = 3'd3,
    REG_SENS_INV     = 3'd4,
    REG_LIGHT_PRES   = 3'd5,
    REG_MOTION_PRES  = 3'd6,
    REG_SENS_PRES    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] on_time_seconds;
    logic [6:0]  sensitivity;
    logic        auto_mode;
    logic [11:0] light_margin;
    logic        sens_pin_inverted;
    logic        light_sensor_present;
    logic        motion_sensor_present;
    logic        sens_output_present;
  } cfg_t;

  typedef struct packed {
    logic        lamp_on;
    logic        lamp_write;
    logic [6:0]  sens_duty;
    logic        sens_write;
    logic [15:0] seconds_left;
    logic        dark_flag;
    logic        warning_active;
  } result_t;

endpackage

// ===== rtl/mlt_cfg.sv =====
`timescale 1ns / 1ps
module mlt_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mlt_pkg::CfgIndexW-1:0]    cfg_index,
  input  logic [mlt_pkg::CfgDataW-1:0]     cfg_data,
  output mlt_pkg::cfg_t                    cfg
);
  import mlt_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.on_time_seconds       <= RST_ON_TIME;
      cfg.sensitivity           <= RST_SENS;
      cfg.auto_mode             <= 1'b0;
      cfg.light_margin          <= RST_MARGIN;
      cfg.sens_pin_inverted     <= 1'b0;
      cfg.light_sensor_present  <= 1'b1;
      cfg.motion_sensor_present <= 1'b1;
      cfg.sens_output_present   <= 1'b1;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_ON_TIME:      cfg.on_time_seconds       <= cfg_data;
        REG_SENSITIVITY:  cfg.sensitivity           <= cfg_data[6:0];
        REG_AUTO_MODE:    cfg.auto_mode             <= cfg_data[0];
        REG_LIGHT_MARGIN: cfg.light_margin          <= cfg_data[11:0];
        REG_SENS_INV:     cfg.sens_pin_inverted     <= cfg_data[0];
        REG_LIGHT_PRES:   cfg.light_sensor_present  <= cfg_data[0];
        REG_MOTION_PRES:  cfg.motion_sensor_present <= cfg_data[0];
        REG_SENS_PRES:    cfg.sens_output_present   <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/mlt_core.sv =====
`timescale 1ns / 1ps
module mlt_core (
  input  logic              clk,
  input  logic              rst,
  input  mlt_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        cmd,
  input  logic [11:0]       light_level,
  input  logic              motion,
  output logic              res_valid,
  input  logic              res_ready,
  output mlt_pkg::result_t  res
);
  import mlt_pkg::*;

  // input register
  logic        s1_valid;
  cmd_t        s1_cmd;
  logic [11:0] s1_light;
  logic        s1_motion;

  // controller state
  logic [15:0] countdown, countdown_next;
  logic        dark_state, dark_state_next;
  logic        blink_running, blink_running_next;
  logic [2:0]  blink_step, blink_step_next;
  logic [9:0]  blink_elapsed_ms, blink_elapsed_ms_next;
  logic        lamp_level, lamp_level_next;

  logic        lamp_strobe;
  logic        sens_strobe;
  logic        fire;
  logic        motion_eff;
  logic        retrig;
  logic [15:0] cd_tmp;
  logic [10:0] elapsed_sum;
  logic [9:0]  blink_dur;
  logic [2:0]  step_inc;
  logic [6:0]  sens_sat;
  logic [6:0]  duty;

  assign in_ready  = !s1_valid || res_ready;
  assign res_valid = s1_valid;
  assign fire      = s1_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_cmd    <= cmd_t'(cmd);
      s1_light  <= light_level;
      s1_motion <= motion;
    end
  end

  assign sens_sat = (cfg.sensitivity > FULL_DUTY) ? FULL_DUTY : cfg.sensitivity;
  assign duty     = cfg.sens_pin_inverted ? (FULL_DUTY - sens_sat) : sens_sat;

  assign blink_dur   = blink_step[0] ? BLINK_LIT_MS : BLINK_DARK_MS;
  assign elapsed_sum = {1'b0, blink_elapsed_ms} + {1'b0, FAST_TICK_MS};
  assign step_inc    = blink_step + 3'd1;

  always_comb begin
    countdown_next        = countdown;
    dark_state_next       = dark_state;
    blink_running_next    = blink_running;
    blink_step_next       = blink_step;
    blink_elapsed_ms_next = blink_elapsed_ms;
    lamp_level_next       = lamp_level;
    lamp_strobe           = 1'b0;
    sens_strobe           = 1'b0;
    motion_eff            = cfg.motion_sensor_present && s1_motion;
    retrig                = 1'b0;
    cd_tmp                = countdown;

    case (s1_cmd)
      CMD_SECOND: begin
        sens_strobe = cfg.sens_output_present;
        if (cfg.auto_mode) begin
          dark_state_next = cfg.light_sensor_present ? (s1_light > cfg.light_margin) : 1'b1;
          retrig = motion_eff && (dark_state_next || (countdown != 16'd0));
          if (retrig) begin
            cd_tmp                = cfg.on_time_seconds;
            blink_running_next    = 1'b0;
            blink_step_next       = 3'd0;
            blink_elapsed_ms_next = 10'd0;
            lamp_level_next       = 1'b1;
            lamp_strobe           = 1'b1;
          end
          countdown_next = cd_tmp;
          if (cd_tmp != 16'd0) begin
            countdown_next = cd_tmp - 16'd1;
            if (cd_tmp == 16'd1) begin
              blink_running_next    = 1'b0;
              blink_step_next       = 3'd0;
              blink_elapsed_ms_next = 10'd0;
              lamp_level_next       = 1'b0;
              lamp_strobe           = 1'b1;
            end else if ((cd_tmp == WARN_SECONDS + 16'd1) && !blink_running_next &&
                         (cfg.on_time_seconds > WARN_SECONDS)) begin
              blink_running_next    = 1'b1;
              blink_step_next       = 3'd0;
              blink_elapsed_ms_next = 10'd0;
              lamp_level_next       = 1'b0;
              lamp_strobe           = 1'b1;
            end
          end
        end else begin
          countdown_next        = 16'd0;
          blink_running_next    = 1'b0;
          blink_step_next       = 3'd0;
          blink_elapsed_ms_next = 10'd0;
        end
      end
      CMD_FAST: begin
        if (blink_running) begin
          if (elapsed_sum[9:0] >= blink_dur) begin
            blink_elapsed_ms_next = 10'd0;
            lamp_strobe           = 1'b1;
            if (step_inc >= BLINK_STEPS) begin
              blink_running_next = 1'b0;
              blink_step_next    = 3'd0;
              lamp_level_next    = 1'b1;
            end else begin
              blink_step_next = step_inc;
              lamp_level_next = step_inc[0];
            end
          end else begin
            blink_elapsed_ms_next = elapsed_sum[9:0];
          end
        end
      end
      CMD_MOTION: begin
        if (cfg.auto_mode && motion_eff && (dark_state || (countdown != 16'd0))) begin
          countdown_next        = cfg.on_time_seconds;
          blink_running_next    = 1'b0;
          blink_step_next       = 3'd0;
          blink_elapsed_ms_next = 10'd0;
          lamp_level_next       = 1'b1;
          lamp_strobe           = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      countdown        <= 16'd0;
      dark_state       <= 1'b0;
      blink_running    <= 1'b0;
      blink_step       <= 3'd0;
      blink_elapsed_ms <= 10'd0;
      lamp_level       <= 1'b0;
    end else if (fire) begin
      countdown        <= countdown_next;
      dark_state       <= dark_state_next;
      blink_running    <= blink_running_next;
      blink_step       <= blink_step_next;
      blink_elapsed_ms <= blink_elapsed_ms_next;
      lamp_level       <= lamp_level_next;
    end
  end

  always_comb begin
    res.lamp_on        = lamp_level_next;
    res.lamp_write     = lamp_strobe;
    res.sens_duty      = duty;
    res.sens_write     = sens_strobe;
    res.seconds_left   = countdown_next;
    res.dark_flag      = dark_state_next;
    res.warning_active = blink_running_next;
  end

  // a running blink always sits inside a live countdown
  a_blink_needs_countdown: assert property (@(posedge clk) disable iff (rst)
    blink_running |-> (countdown != 16'd0))
    else $error("blink running with countdown at zero");

  a_blink_step_range: assert property (@(posedge clk) disable iff (rst)
    blink_running |-> (blink_step < BLINK_STEPS) && (blink_elapsed_ms < BLINK_LIT_MS))
    else $error("blink step or phase timer out of range");

  a_blink_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !blink_running |-> (blink_step == 3'd0) && (blink_elapsed_ms == 10'd0))
    else $error("blink phase left over while idle");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !$past(fire) && !$past(rst) |-> $stable(countdown) && $stable(lamp_level))
    else $error("controller state moved without a transaction");

endmodule

// ===== rtl/mlt_obuf.sv =====
`timescale 1ns / 1ps
module mlt_obuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  mlt_pkg::result_t  push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output mlt_pkg::result_t  pop_data
);
  import mlt_pkg::*;

  result_t    slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slot[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/motion_lamp_timer_with_warning_blink_unit.sv =====
`timescale 1ns / 1ps
// Motion lamp controller with a switch-off warning blink. One event
// (second tick, fast tick or motion change) is taken per clock and each
// event yields exactly one result. An event is held in the input
// register, where the countdown, dark flag and blink state are updated,
// and its result is then registered in a two-entry output queue before
// it is offered; a stalled output only holds the input once both queue
// entries are full. Configuration registers are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while no event
// is in flight, as the block itself does not enforce it.
module motion_lamp_timer_with_warning_blink_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mlt_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [mlt_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    cmd,
  input  logic [11:0]                   light_level,
  input  logic                          motion,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          lamp_on,
  output logic                          lamp_write,
  output logic [6:0]                    sens_duty,
  output logic                          sens_write,
  output logic [15:0]                   seconds_left,
  output logic                          dark_flag,
  output logic                          warning_active
);
  import mlt_pkg::*;

  cfg_t    cfg;
  result_t core_res;
  result_t out_res;
  logic    core_valid;
  logic    core_ready;

  mlt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mlt_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .light_level (light_level),
    .motion      (motion),
    .res_valid   (core_valid),
    .res_ready   (core_ready),
    .res         (core_res)
  );

  mlt_obuf u_obuf (
    .clk        (clk),
    .rst        (rst),
    .push_valid (core_valid),
    .push_ready (core_ready),
    .push_data  (core_res),
    .pop_valid  (out_valid),
    .pop_ready  (out_ready),
    .pop_data   (out_res)
  );

  assign lamp_on        = out_res.lamp_on;
  assign lamp_write     = out_res.lamp_write;
  assign sens_duty      = out_res.sens_duty;
  assign sens_write     = out_res.sens_write;
  assign seconds_left   = out_res.seconds_left;
  assign dark_flag      = out_res.dark_flag;
  assign warning_active = out_res.warning_active;

endmodule
